### rtl/nfa_pkg.sv
// ---------------------------------------------------------------------------
// nfa_pkg: shared definitions for the next-fit block allocator
// Default sizes, field widths, item and result codes, the result record and
// the control state type.
// ---------------------------------------------------------------------------
package nfa_pkg;

  // Default table depth and stored size width.
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Fixed widths of the channel fields.
  localparam int IDX_W   = 4;
  localparam int SIZE_W  = 16;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  // Reset value of the block count register.
  localparam logic [COUNT_W-1:0] COUNT_RST = 5'd16;

  // Item kinds carried on the input tuser line.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_LOADED = 2'd0,
    STAT_ALLOC  = 2'd1,
    STAT_NOFIT  = 2'd2
  } stat_t;

  // One result word as handed from the controller to the output register.
  typedef struct packed {
    stat_t              status;
    logic [IDX_W-1:0]   granted_block;
    logic [SIZE_W-1:0]  leftover;
  } res_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } nfa_state_t;

endpackage

### rtl/nfa_size_mem.sv
// ---------------------------------------------------------------------------
// nfa_size_mem: block size table
// Single-port-write, single-port-read synchronous memory with the read data
// registered. Entries are undefined until loaded.
// ---------------------------------------------------------------------------
module nfa_size_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/nfa_ctrl.sv
// ---------------------------------------------------------------------------
// nfa_ctrl: allocation controller
// Takes one item at a time. Loads write the size table directly; requests
// walk the table one entry a cycle from the search pointer with wrap-around,
// checking each returned size against the request and the used marks.
// ---------------------------------------------------------------------------
module nfa_ctrl import nfa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF,
  parameter int AW         = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Item side
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic                 func,
  input  logic [IDX_W-1:0]     idx,
  input  logic [SIZE_W-1:0]    size,
  input  logic [COUNT_W-1:0]   block_count,
  // Size table
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [SIZE_BITS-1:0] wr_data,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  logic [SIZE_BITS-1:0] rd_data,
  // Result side
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);

  nfa_state_t           state_r, state_nxt;
  logic [MAX_BLOCKS-1:0] used_r, used_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic [CW-1:0]        left_r, left_nxt;
  logic                 chk_valid_r, chk_valid_nxt;
  logic [AW-1:0]        chk_addr_r, chk_addr_nxt;
  logic                 chk_last_r, chk_last_nxt;
  res_t                 res_r, res_nxt;

  logic                 accept;
  logic [CW-1:0]        cnt_in;
  logic                 idx_in_table;
  logic                 hit;

  // Active block count, saturated to the table depth.
  always_comb begin
    if (32'(block_count) > MAX_BLOCKS) begin
      cnt_in = CW'(MAX_BLOCKS);
    end else begin
      cnt_in = CW'(block_count);
    end
  end

  assign accept       = item_valid && item_ready;
  assign idx_in_table = 32'(idx) < MAX_BLOCKS;

  // A checked entry fits when it is free and large enough.
  assign hit = chk_valid_r && !used_r[chk_addr_r] && (rd_data >= req_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          if (func == FUNC_LOAD || cnt_in == '0) begin
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit || (chk_valid_r && chk_last_r)) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State-decoded outputs.
  always_comb begin
    item_ready = 1'b0;
    rd_en      = 1'b0;
    res_valid  = 1'b0;
    case (state_r)
      ST_IDLE:   item_ready = 1'b1;
      ST_SCAN:   rd_en      = (left_r != '0);
      ST_RESULT: res_valid  = 1'b1;
      default:   item_ready = 1'b0;
    endcase
  end

  // Table write for loads and read address for the scan.
  assign wr_en   = accept && (func == FUNC_LOAD) && idx_in_table;
  assign wr_addr = AW'(idx);
  assign wr_data = SIZE_BITS'(size);
  assign rd_addr = addr_r;
  assign res     = res_r;

  // Datapath and bookkeeping.
  always_comb begin
    used_nxt      = used_r;
    ptr_nxt       = ptr_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    left_nxt      = left_r;
    chk_valid_nxt = rd_en && !hit;
    chk_addr_nxt  = addr_r;
    chk_last_nxt  = (left_r == CW'(1));
    res_nxt       = res_r;

    if (accept) begin
      res_nxt.status        = STAT_LOADED;
      res_nxt.granted_block = '0;
      res_nxt.leftover      = '0;
      if (func == FUNC_LOAD) begin
        if (idx_in_table) begin
          used_nxt[AW'(idx)] = 1'b0;
        end
        ptr_nxt = '0;
      end else begin
        // Start at the pointer if it lies inside the active range.
        req_nxt  = SIZE_BITS'(size);
        cnt_nxt  = cnt_in;
        left_nxt = cnt_in;
        if (32'(ptr_r) < 32'(cnt_in)) begin
          addr_nxt = ptr_r;
        end else begin
          addr_nxt = '0;
        end
        if (cnt_in == '0) begin
          res_nxt.status = STAT_NOFIT;
        end
      end
    end

    // Issue the next read, wrapping at the active count.
    if (rd_en) begin
      left_nxt = left_r - CW'(1);
      if (CW'(addr_r) + CW'(1) == cnt_r) begin
        addr_nxt = '0;
      end else begin
        addr_nxt = addr_r + AW'(1);
      end
    end

    // Resolve the scan.
    if (hit) begin
      used_nxt[chk_addr_r]  = 1'b1;
      ptr_nxt               = chk_addr_r;
      res_nxt.status        = STAT_ALLOC;
      res_nxt.granted_block = IDX_W'(chk_addr_r);
      res_nxt.leftover      = SIZE_W'(rd_data - req_r);
      left_nxt              = '0;
    end else if (chk_valid_r && chk_last_r) begin
      res_nxt.status        = STAT_NOFIT;
      res_nxt.granted_block = '0;
      res_nxt.leftover      = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      ptr_r       <= '0;
      left_r      <= '0;
      chk_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ptr_r       <= ptr_nxt;
      left_r      <= left_nxt;
      chk_valid_r <= chk_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cnt_r      <= cnt_nxt;
    addr_r     <= addr_nxt;
    chk_addr_r <= chk_addr_nxt;
    chk_last_r <= chk_last_nxt;
    res_r      <= res_nxt;
  end

`ifndef SYNTHESIS
  // A returned table word is only checked while a scan is running.
  assert property (@(posedge clk) disable iff (!rst_n)
    chk_valid_r |-> state_r == ST_SCAN)
    else $error("nfa_ctrl: check stage active outside a scan");

  // A load always returns the search pointer to the first entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && func == FUNC_LOAD) |=> ptr_r == '0)
    else $error("nfa_ctrl: pointer not cleared by a load");

  // A granted block is marked used and becomes the new pointer.
  assert property (@(posedge clk) disable iff (!rst_n)
    hit |=> (used_r[ptr_r] && state_r == ST_RESULT && res_r.status == STAT_ALLOC))
    else $error("nfa_ctrl: grant not recorded");

  // With no active block a request is refused at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && func == FUNC_ALLOC && cnt_in == '0)
      |=> (state_r == ST_RESULT && res_r.status == STAT_NOFIT))
    else $error("nfa_ctrl: empty table request not refused");
`endif

endmodule

### rtl/next_fit_block_allocator.sv
// ---------------------------------------------------------------------------
// next_fit_block_allocator: next-fit allocator over a table of memory blocks
// Configuration register, size table, controller and output register.
//   The in_ channel carries one word per item; in_tuser selects a load or an
//   allocation request. A load writes one block size, frees the block and
//   returns the search pointer to entry 0. A request takes the first free
//   block large enough, searching from the pointer with wrap-around. Each
//   item yields one word on the out_ channel. The cfg_ channel writes the
//   active block count and is always ready; it is to be written only while
//   idle, by the user, as the block does not enforce this. One item is
//   worked on at a time; a request scans one table entry per cycle through
//   the registered read port, over at most N entries, N being the active
//   block count. A new item is taken only after the last result has moved
//   on to the output register. The output register holds a finished word,
//   so one more item is taken while the receiver stalls; its result waits
//   in the controller, which then stops accepting until the output register
//   is freed.
//   Reset (synchronous, active low) frees all blocks, clears the pointer and
//   sets the block count to 16; block sizes stay undefined until loaded.
// ---------------------------------------------------------------------------
module next_fit_block_allocator import nfa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input item channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [23:0]         in_tdata,   // block_index[3:0], size[19:4], zero [23:20]
  input  logic                in_tuser,   // func[0]
  // Result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // granted_block[3:0], leftover[19:4], zero [23:20]
  output logic [STAT_W-1:0]   out_tuser,  // status[1:0]
  // Configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_data    // block_count[4:0]
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  logic [COUNT_W-1:0]   block_count_r;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 res_valid;
  logic                 res_ready;
  res_t                 res;
  logic                 out_valid_r;
  res_t                 out_res_r;

  // Block count register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      block_count_r <= cfg_data;
    end
  end

  // Size table.
  nfa_size_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (SIZE_BITS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Controller.
  nfa_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .AW         (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_tvalid),
    .item_ready  (in_tready),
    .func        (in_tuser),
    .idx         (in_tdata[3:0]),
    .size        (in_tdata[19:4]),
    .block_count (block_count_r),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register, refilled in the cycle it is taken.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {4'b0000, out_res_r.leftover, out_res_r.granted_block};

endmodule

### tb/next_fit_block_allocator_tb.sv
// ---------------------------------------------------------------------------
// next_fit_block_allocator_tb: self-checking bench for the next-fit allocator
// Loads block sizes and sends allocation requests on the input stream under
// several block counts. A local next-fit predictor works out the answer for
// each accepted word. The monitor checks every result word, field by field,
// against the oldest outstanding answer. Both sides stall at random, and the
// receiver holds off once for a long stretch so that the block backs up.
// ---------------------------------------------------------------------------
module next_fit_block_allocator_tb;
  import nfa_pkg::*;

  // One input item: load or request, table entry and size.
  typedef struct {
    logic              func;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
  } alloc_item_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [23:0]         in_tdata  = '0;
  logic                in_tuser  = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [23:0]         out_tdata;
  logic [STAT_W-1:0]   out_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  cfg_data  = '0;

  // Predictor state: mirrors the table, the marks, the pointer and the count.
  logic [SIZE_W-1:0]   blk_size [MAX_BLOCKS_DEF];
  logic                blk_used [MAX_BLOCKS_DEF];
  int                  scan_ptr  = 0;
  logic [COUNT_W-1:0]  blk_count = COUNT_RST;

  alloc_item_t         alloc_items_q[$];
  res_t                alloc_answers_q[$];
  alloc_item_t         on_bus;
  int                  send_gap   = 0;
  int                  stall_left = 0;
  int                  hold_req   = 0;
  int                  mismatches = 0;
  bit                  calm       = 1'b0;

  next_fit_block_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // block_index[3:0], size[19:4], zero [23:20]
    .in_tuser   (in_tuser),   // func[0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // granted_block[3:0], leftover[19:4], zero [23:20]
    .out_tuser  (out_tuser),  // status[1:0]
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)    // block_count[4:0]
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Next-fit answer for one item; updates the local table state.
  function automatic res_t next_fit_answer(input alloc_item_t it);
    res_t r;
    int   lim;
    int   hit;
    int   n;
    r = '0;
    r.status = STAT_LOADED;
    if (it.func == FUNC_LOAD) begin
      blk_size[it.idx] = it.size;
      blk_used[it.idx] = 1'b0;
      scan_ptr = 0;
      return r;
    end
    lim = (blk_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(blk_count);
    hit = -1;
    // Forward pass from the pointer, then the wrapped pass below it.
    for (n = scan_ptr; n < lim && hit < 0; n++)
      if (!blk_used[n] && blk_size[n] >= it.size) hit = n;
    for (n = 0; n < scan_ptr && n < lim && hit < 0; n++)
      if (!blk_used[n] && blk_size[n] >= it.size) hit = n;
    if (hit < 0) begin
      r.status = STAT_NOFIT;
    end else begin
      blk_used[hit] = 1'b1;
      scan_ptr = hit;
      r.status = STAT_ALLOC;
      r.granted_block = hit[IDX_W-1:0];
      r.leftover = blk_size[hit] - it.size;
    end
    return r;
  endfunction

  task automatic push_load(input int idx, input int size);
    alloc_item_t it;
    it.func = FUNC_LOAD;
    it.idx  = idx[IDX_W-1:0];
    it.size = size[SIZE_W-1:0];
    alloc_items_q.push_back(it);
  endtask

  // The index field of a request is ignored, so it carries random bits.
  task automatic push_request(input int size);
    alloc_item_t it;
    it.func = FUNC_ALLOC;
    it.idx  = IDX_W'($urandom_range(0, 15));
    it.size = size[SIZE_W-1:0];
    alloc_items_q.push_back(it);
  endtask

  // Wait until every word has been sent and every answer has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (alloc_items_q.size() != 0 || in_tvalid || alloc_answers_q.size() != 0);
  endtask

  task automatic write_block_count(input int cnt);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cnt[COUNT_W-1:0];
    do @(posedge clk);
    while (!cfg_ready);
    blk_count = cnt[COUNT_W-1:0];
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic flag_mismatch(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected status %0d block %0d leftover %0d,",
               what, want.status, want.granted_block, want.leftover);
      $display("  got status %0d block %0d leftover %0d",
               got.status, got.granted_block, got.leftover);
    end
  endtask

  // Driver: offers queued words, predicting the answer as each is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        alloc_answers_q.push_back(next_fit_answer(on_bus));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (alloc_items_q.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 4);
          in_tvalid <= 1'b0;
        end else if (alloc_items_q.size() != 0) begin
          on_bus = alloc_items_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0000, on_bus.size, on_bus.idx};
          in_tuser  <= on_bus.func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word and drives the receiver's stalls.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status        = stat_t'(out_tuser);
        got.granted_block = out_tdata[3:0];
        got.leftover      = out_tdata[19:4];
        if (alloc_answers_q.size() == 0) begin
          flag_mismatch("unexpected word", '0, got);
        end else begin
          want = alloc_answers_q.pop_front();
          if (got.status !== want.status) flag_mismatch("status", want, got);
          if (got.granted_block !== want.granted_block) flag_mismatch("block", want, got);
          if (got.leftover !== want.leftover) flag_mismatch("leftover", want, got);
        end
      end
      // A requested long hold overrides the short random stalls.
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus: directed checks, then random phases under several block counts.
  initial begin
    int counts[9];
    int ph;
    int k;
    bit wide;
    counts = '{16, 1, 0, 31, 17, 2, 0, 8, 16};
    counts[6] = $urandom_range(0, 31);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every entry is loaded before any request can read the table.
    push_load(0, 0);
    push_load(15, 65535);
    for (k = 1; k < 15; k++) push_load(k, 100 * k + 50);
    push_request(65535);   // only the largest block fits, no leftover
    push_request(0);       // zero request wraps round to the empty block
    push_request(300);
    push_request(300);
    push_request(60000);   // nothing large enough is free
    push_load(13, 65535);  // load frees the block and rewinds the pointer
    push_request(65535);
    wait_idle();

    // Pointer left beyond the count: only the wrapped pass is searched.
    write_block_count(4);
    push_request(1);
    wait_idle();
    // Single block, then no blocks at all.
    write_block_count(1);
    push_load(0, 1000);
    push_request(500);
    push_request(10);
    wait_idle();
    write_block_count(0);
    push_request(0);
    wait_idle();

    // Random phases: mostly requests against blocks refreshed by loads.
    for (ph = 0; ph < 9; ph++) begin
      write_block_count(counts[ph]);
      calm = (ph == 8);
      for (k = 0; k < 50; k++) begin
        wide = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 30)
          push_load($urandom_range(0, 15), wide ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 1023));
        else
          push_request(wide ? $urandom_range(0, 65535) : $urandom_range(0, 1023));
      end
      // Long receiver hold-off while the sender keeps offering words.
      if (ph == 0) hold_req = 80;
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && alloc_answers_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Run limit far above the slowest correct run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/nfa_pkg.sv
rtl/nfa_size_mem.sv
rtl/nfa_ctrl.sv
rtl/next_fit_block_allocator.sv
tb/next_fit_block_allocator_tb.sv
